[rtl/ewsm_pkg.sv]
// ----------------------------------------------------------------------------
// ewsm_pkg
// Shared types and codes of the event window sequence matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ewsm_pkg;

    localparam int OPCODE_W   = 2;
    localparam int CODE_W     = 8;
    localparam int KEYS_W     = 64;
    localparam int LEN_W      = 4;
    localparam int TOL_W      = 4;
    localparam int CAP_W      = 4;
    localparam int MASK_W     = 8;
    localparam int COUNT_W    = 4;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CODE_W-1:0]   event_code;
        logic [KEYS_W-1:0]   pattern_keys;
        logic [LEN_W-1:0]    pattern_length;
        logic [TOL_W-1:0]    skip_tolerance;
    } ewsm_item_t;

    typedef struct packed {
        logic                found;
        logic [MASK_W-1:0]   match_mask;
        logic [COUNT_W-1:0]  event_count;
    } ewsm_result_t;

endpackage

`default_nettype wire

[rtl/ewsm_ram.sv]
// ----------------------------------------------------------------------------
// ewsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ewsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ewsm_ctrl.sv]
// ----------------------------------------------------------------------------
// ewsm_ctrl
// Window bookkeeping and search sequencer around the event RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ewsm_ctrl import ewsm_pkg::*; #(
    parameter int WINDOW_DEPTH = 8,
    parameter int MAX_PATTERN  = 8,
    parameter int KEY_BITS     = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CAP_W-1:0]   capacity,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ewsm_item_t         in_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ewsm_result_t            res
);

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int NT_W   = $clog2(MAX_PATTERN + 1);
    localparam int NT_IW  = ($clog2(MAX_PATTERN) > 0) ? $clog2(MAX_PATTERN) : 1;
    localparam int KBUF_W = MAX_PATTERN * KEY_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PUSH   = 3'd1;
    localparam logic [2:0] ST_S_NEXT = 3'd2;
    localparam logic [2:0] ST_S_READ = 3'd3;
    localparam logic [2:0] ST_S_CMP  = 3'd4;
    localparam logic [2:0] ST_S_MASK = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // (ptr + pos) mod depth, both operands below depth
    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0] ptr,
        input logic [CNT_W-1:0] pos
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(WINDOW_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(WINDOW_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [2:0]              state_reg,   state_next;
    logic [CNT_W-1:0]        held_reg,    held_next;
    logic [PTR_W-1:0]        oldest_reg,  oldest_next;
    logic [CNT_W-1:0]        cursor_reg,  cursor_next;
    logic [WINDOW_DEPTH-1:0] marks_reg,   marks_next;
    logic [CNT_W-1:0]        k_reg,       k_next;
    logic [CNT_W-1:0]        j_reg,       j_next;
    logic [NT_W-1:0]         ntaken_reg,  ntaken_next;
    logic [TOL_W-1:0]        skips_reg,   skips_next;
    logic [WINDOW_DEPTH-1:0] taken_reg,   taken_next;
    logic [WINDOW_DEPTH-1:0] newly_reg,   newly_next;
    logic [PTR_W-1:0]        slot_reg,    slot_next;
    logic                    found_reg,   found_next;
    logic [MASK_W-1:0]       mask_reg,    mask_next;

    // item payload, no reset
    logic [KBUF_W-1:0]       keys_reg;
    logic [NT_W-1:0]         len_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [KEY_BITS-1:0]     code_reg;

    logic                    ram_we;
    logic [PTR_W-1:0]        ram_waddr;
    logic [PTR_W-1:0]        ram_raddr;
    logic [KEY_BITS-1:0]     ram_rdata;

    logic                    accept;
    logic [CW-1:0]           eff_cap;
    logic                    drop;
    logic [PTR_W-1:0]        push_oldest;
    logic [CNT_W-1:0]        push_held;
    logic [PTR_W-1:0]        push_slot;
    logic [KEY_BITS-1:0]     key_cur;
    logic                    key_hit;
    logic [WINDOW_DEPTH-1:0] taken_new;
    logic [NT_W-1:0]         len_clamped;

    ewsm_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_event_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (code_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);

    assign res.found       = found_reg;
    assign res.match_mask  = mask_reg;
    assign res.event_count = COUNT_W'(held_reg);

    // capacity zero acts as one, above the depth acts as the depth
    always_comb
    begin
        eff_cap = CW'(capacity);
        if (capacity == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(capacity) > CW'(WINDOW_DEPTH))
        begin
            eff_cap = CW'(WINDOW_DEPTH);
        end
    end

    assign drop        = (CW'(held_reg) >= eff_cap) && (held_reg != '0);
    assign push_oldest = drop ? wrap_add(oldest_reg, CNT_W'(1)) : oldest_reg;
    assign push_held   = drop ? held_reg - CNT_W'(1) : held_reg;
    assign push_slot   = wrap_add(push_oldest, push_held);

    assign key_cur   = keys_reg[ntaken_reg[NT_IW-1:0] * KEY_BITS +: KEY_BITS];
    assign key_hit   = (ram_rdata == key_cur);
    assign taken_new = taken_reg | (WINDOW_DEPTH'(1) << slot_reg);

    assign len_clamped = (in_item.pattern_length > LEN_W'(MAX_PATTERN))
                       ? NT_W'(MAX_PATTERN) : NT_W'(in_item.pattern_length);

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        oldest_next = oldest_reg;
        cursor_next = cursor_reg;
        marks_next  = marks_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        ntaken_next = ntaken_reg;
        skips_next  = skips_reg;
        taken_next  = taken_reg;
        newly_next  = newly_reg;
        slot_next   = slot_reg;
        found_next  = found_reg;
        mask_next   = mask_reg;
        ram_we      = 1'b0;
        ram_waddr   = push_slot;
        ram_raddr   = wrap_add(oldest_reg, j_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    mask_next  = '0;
                    case (in_item.opcode)
                        OP_PUSH:
                        begin
                            state_next = ST_PUSH;
                        end
                        OP_SEARCH:
                        begin
                            k_next     = cursor_reg;
                            state_next = (len_clamped == '0) ? ST_DONE : ST_S_NEXT;
                        end
                        OP_CLEAR:
                        begin
                            marks_next  = '0;
                            held_next   = '0;
                            oldest_next = '0;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PUSH:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - CNT_W'(1);
                end
                oldest_next           = push_oldest;
                held_next             = push_held + CNT_W'(1);
                ram_we                = 1'b1;
                marks_next[push_slot] = 1'b0;
                state_next            = ST_DONE;
            end

            // start a new attempt at position k
            ST_S_NEXT:
            begin
                if (k_reg >= held_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    j_next      = k_reg;
                    ntaken_next = '0;
                    skips_next  = '0;
                    taken_next  = '0;
                    state_next  = ST_S_READ;
                end
            end

            ST_S_READ:
            begin
                if (j_reg >= held_reg)
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_S_NEXT;
                end
                else
                begin
                    slot_next  = ram_raddr;
                    state_next = ST_S_CMP;
                end
            end

            ST_S_CMP:
            begin
                if (key_hit)
                begin
                    if (ntaken_reg + NT_W'(1) == len_reg)
                    begin
                        marks_next  = marks_reg | taken_new;
                        newly_next  = taken_new & ~marks_reg;
                        cursor_next = j_reg + CNT_W'(1);
                        found_next  = 1'b1;
                        state_next  = ST_S_MASK;
                    end
                    else
                    begin
                        ntaken_next = ntaken_reg + NT_W'(1);
                        taken_next  = taken_new;
                        j_next      = j_reg + CNT_W'(1);
                        state_next  = ST_S_READ;
                    end
                end
                // first entry must equal key 0, else the skip budget is spent
                else if ((ntaken_reg == '0) || (skips_reg >= tol_reg))
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_S_NEXT;
                end
                else
                begin
                    skips_next = skips_reg + TOL_W'(1);
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_S_READ;
                end
            end

            // newly marked slots back to window positions
            ST_S_MASK:
            begin
                for (int p = 0; p < MASK_W; p++)
                begin
                    if (p < WINDOW_DEPTH)
                    begin
                        mask_next[p] = newly_reg[wrap_add(oldest_reg, CNT_W'(p))];
                    end
                    else
                    begin
                        mask_next[p] = 1'b0;
                    end
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            held_reg   <= '0;
            oldest_reg <= '0;
            cursor_reg <= '0;
            marks_reg  <= '0;
            k_reg      <= '0;
            j_reg      <= '0;
            ntaken_reg <= '0;
            skips_reg  <= '0;
            taken_reg  <= '0;
            newly_reg  <= '0;
            slot_reg   <= '0;
            found_reg  <= 1'b0;
            mask_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
            cursor_reg <= cursor_next;
            marks_reg  <= marks_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            ntaken_reg <= ntaken_next;
            skips_reg  <= skips_next;
            taken_reg  <= taken_next;
            newly_reg  <= newly_next;
            slot_reg   <= slot_next;
            found_reg  <= found_next;
            mask_reg   <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            keys_reg <= in_item.pattern_keys[KBUF_W-1:0];
            len_reg  <= len_clamped;
            tol_reg  <= in_item.skip_tolerance;
            code_reg <= in_item.event_code[KEY_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/event_window_sequence_matcher.sv]
// ----------------------------------------------------------------------------
// event_window_sequence_matcher
// Sliding window of event codes with a gap-tolerant subsequence search.
// ----------------------------------------------------------------------------
// One beat is taken at a time and answered with exactly one result beat.
// A push passes through the PUSH and DONE states before its result is
// loaded into the output register; a clear, an unknown opcode or a
// zero-length search goes straight to DONE. A search walks the window
// through the S_READ and S_CMP states for each entry, since each
// compare waits on the registered read of the event RAM; it ends sooner
// when the cursor is near the end of the window or the pattern fails
// early. A result waiting in the output register does not block the
// next input beat. There is no clearing pass after reset; the user must
// write window_capacity through cfg_we / cfg_wdata only while the block
// is idle, which the block itself does not enforce.
`default_nettype none

module event_window_sequence_matcher import ewsm_pkg::*; #(
    parameter int WINDOW_DEPTH = 8,
    parameter int MAX_PATTERN  = 8,
    parameter int KEY_BITS     = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // window_capacity register
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    // input beats
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [79:0]       s_tdata,  // event_code, pattern_keys, pattern_length,
                                             // skip_tolerance
    input  wire logic [1:0]        s_tuser,  // opcode
    // result beats
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata   // found, match_mask, event_count, zero pad
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [15:0]      m_tdata_reg;

    ewsm_item_t       item;
    ewsm_result_t     res;
    logic             res_valid;
    logic             res_ready;

    assign item.opcode         = s_tuser;
    assign item.event_code     = s_tdata[7:0];
    assign item.pattern_keys   = s_tdata[71:8];
    assign item.pattern_length = s_tdata[75:72];
    assign item.skip_tolerance = s_tdata[79:76];

    ewsm_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_PATTERN  (MAX_PATTERN),
        .KEY_BITS     (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    // output register frees as its beat leaves
    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = (res_valid && res_ready) ? 1'b1
                         : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {3'b000, res.event_count, res.match_mask, res.found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[tb/sv/event_window_sequence_matcher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_window_sequence_matcher_test
// Self-checking bench for the event window sequence matcher. Input beats are
// queued per phase, and each phase runs under its own window capacity. A
// sender process offers the beats in random bursts. An in-bench model of the
// window predicts the reply to every accepted beat. A receiver process
// stalls on its own pattern and checks each reply beat against the oldest
// prediction.
// ----------------------------------------------------------------------------

module event_window_sequence_matcher_test;

    import ewsm_pkg::*;

    localparam int DEPTH            = 8;
    localparam int MAX_KEYS         = 8;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 200;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int MAX_REPORTS      = 40;

    // the package leaves the fourth opcode unnamed; the block must ignore it
    localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 2'd3;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata  = '0;
    logic               s_tvalid   = 1'b0;
    logic               s_tready;
    logic [79:0]        s_tdata    = '0;  // event_code, pattern_keys, pattern_length,
                                          // skip_tolerance
    logic [1:0]         s_tuser    = '0;  // opcode
    logic               m_tvalid;
    logic               m_tready   = 1'b0;
    logic [15:0]        m_tdata;          // found, match_mask, event_count, zero pad

    event_window_sequence_matcher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // window model
    logic [CODE_W-1:0]  window_codes [DEPTH];
    logic               window_marks [DEPTH];
    int                 head_slot;
    int                 fill_count;
    int                 resume_pos;
    logic [CAP_W-1:0]   capacity_setting;

    ewsm_item_t         beats_to_send [$];
    ewsm_result_t       replies_due [$];
    ewsm_item_t         current_beat;

    int                 beats_accepted = 0;
    int                 replies_checked = 0;
    int                 hits_seen = 0;
    int                 marked_seen = 0;
    int                 error_count = 0;

    logic               sender_idles = 1'b0;
    logic               receiver_idles = 1'b0;
    logic               long_hold_request = 1'b0;
    logic               long_hold_done = 1'b0;

    int                 gap_left = 0;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 run_left = 0;
    int                 long_hold_left = 0;

    function automatic int slot_of(input int pos);
        return (head_slot + pos) % DEPTH;
    endfunction

    function automatic ewsm_result_t apply_to_window(input ewsm_item_t beat);
        ewsm_result_t reply;
        int           cap;
        int           keys_len;
        int           skips;
        int           taken_n;
        int           taken_pos [MAX_KEYS];
        logic         hit;
        reply = '0;
        hit = 1'b0;
        case (beat.opcode)
            OP_PUSH:
            begin
                cap = (capacity_setting == 0) ? 1 :
                      (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
                if (resume_pos > 0)
                    resume_pos--;
                // a lowered capacity still drops only one entry per push
                if (fill_count >= cap && fill_count > 0)
                begin
                    head_slot = (head_slot + 1) % DEPTH;
                    fill_count--;
                end
                window_codes[slot_of(fill_count)] = beat.event_code;
                window_marks[slot_of(fill_count)] = 1'b0;
                fill_count++;
            end
            OP_SEARCH:
            begin
                keys_len = (beat.pattern_length > MAX_KEYS) ? MAX_KEYS
                                                            : int'(beat.pattern_length);
                if (keys_len != 0)
                begin
                    for (int k = resume_pos; k < fill_count && !hit; k++)
                    begin
                        if (window_codes[slot_of(k)] != beat.pattern_keys[0 +: CODE_W])
                            continue;
                        taken_n = 0;
                        skips = 0;
                        for (int j = k; j < fill_count; j++)
                        begin
                            if (window_codes[slot_of(j)] ==
                                beat.pattern_keys[taken_n*CODE_W +: CODE_W])
                            begin
                                taken_pos[taken_n] = j;
                                taken_n++;
                                if (taken_n == keys_len)
                                begin
                                    for (int m = 0; m < taken_n; m++)
                                    begin
                                        if (!window_marks[slot_of(taken_pos[m])])
                                            reply.match_mask[taken_pos[m]] = 1'b1;
                                        window_marks[slot_of(taken_pos[m])] = 1'b1;
                                    end
                                    resume_pos = j + 1;
                                    hit = 1'b1;
                                    break;
                                end
                            end
                            else
                            begin
                                skips++;
                                if (skips > int'(beat.skip_tolerance))
                                    break;
                            end
                        end
                    end
                end
                reply.found = hit;
            end
            OP_CLEAR:
            begin
                // the scan position survives a clear
                for (int i = 0; i < DEPTH; i++)
                    window_marks[i] = 1'b0;
                fill_count = 0;
                head_slot = 0;
            end
            default:
            begin
            end
        endcase
        reply.event_count = fill_count[COUNT_W-1:0];
        return reply;
    endfunction

    // sender: one beat in flight, bursts with gaps between them
    always @(posedge clk)
    begin : sender
        logic offer;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                replies_due.insert(replies_due.size(), apply_to_window(current_beat));
                beats_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (beats_to_send.size() != 0)
                begin
                    current_beat = beats_to_send[0];
                    beats_to_send.delete(0);
                    offer = 1'b1;
                    if (sender_idles)
                    begin
                        if (burst_left > 0)
                            burst_left--;
                        else
                        begin
                            burst_left = $urandom_range(0, 15);
                            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                                   : $urandom_range(1, 6);
                        end
                    end
                end
                s_tvalid <= offer;
                if (offer)
                begin
                    s_tdata <= {current_beat.skip_tolerance, current_beat.pattern_length,
                                current_beat.pattern_keys, current_beat.event_code};
                    s_tuser <= current_beat.opcode;
                end
            end
        end
    end

    // receiver: runs of ready broken by stalls, plus one long hold-off on request
    always @(posedge clk)
    begin : receiver
        logic ready_next;
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            ready_next = 1'b0;
        end
        else if (long_hold_request && !long_hold_done)
        begin
            long_hold_left = LONG_HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
            ready_next = 1'b0;
        end
        else if (!receiver_idles)
            ready_next = 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
            ready_next = 1'b1;
        end
        else
        begin
            run_left = $urandom_range(0, 10);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 5);
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    always @(posedge clk)
    begin : reply_check
        ewsm_result_t seen;
        ewsm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.found = m_tdata[0];
            seen.match_mask = m_tdata[8:1];
            seen.event_count = m_tdata[12:9];
            if (replies_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $error("reply beat with no prediction waiting: %h", m_tdata);
            end
            else
            begin
                want = replies_due[0];
                replies_due.delete(0);
                replies_checked++;
                if (seen.found)
                    hits_seen++;
                if (seen.match_mask != '0)
                    marked_seen++;
                if (seen.found != want.found)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("found: expected %0d, got %0d", want.found, seen.found);
                end
                if (seen.match_mask != want.match_mask)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("match_mask: expected %b, got %b",
                               want.match_mask, seen.match_mask);
                end
                if (seen.event_count != want.event_count)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("event_count: expected %0d, got %0d",
                               want.event_count, seen.event_count);
                end
            end
        end
    end

    function automatic ewsm_item_t random_beat(input logic [OPCODE_W-1:0] op);
        ewsm_item_t beat;
        beat.opcode = op;
        beat.event_code = CODE_W'($urandom_range(0, 255));
        beat.pattern_keys = {$urandom(), $urandom()};
        beat.pattern_length = LEN_W'($urandom_range(0, 15));
        beat.skip_tolerance = TOL_W'($urandom_range(0, 15));
        return beat;
    endfunction

    task automatic queue_beat(input ewsm_item_t beat);
        beats_to_send.insert(beats_to_send.size(), beat);
    endtask

    task automatic queue_push(input logic [CODE_W-1:0] code);
        ewsm_item_t beat;
        beat = random_beat(OP_PUSH);
        beat.event_code = code;
        queue_beat(beat);
    endtask

    task automatic queue_search(input logic [KEYS_W-1:0] keys, input logic [LEN_W-1:0] len,
                                input logic [TOL_W-1:0] tol);
        ewsm_item_t beat;
        beat = random_beat(OP_SEARCH);
        beat.pattern_keys = keys;
        beat.pattern_length = len;
        beat.skip_tolerance = tol;
        queue_beat(beat);
    endtask

    task automatic queue_random_phase(input int count);
        logic [CODE_W-1:0] alphabet [4];
        logic [KEYS_W-1:0] keys;
        int                roll;
        int                keys_len;
        for (int a = 0; a < 4; a++)
            alphabet[a] = ($urandom_range(0, 5) == 0) ? {CODE_W{a[0]}}
                                                      : CODE_W'($urandom_range(0, 255));
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                queue_push(alphabet[$urandom_range(0, 3)]);
            else if (roll < 52)
                queue_push(CODE_W'($urandom_range(0, 255)));
            else if (roll < 90)
            begin
                // mostly short patterns over the phase's few codes, so hits are common
                keys_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 3);
                keys = {$urandom(), $urandom()};
                if ($urandom_range(0, 9) != 0)
                    for (int b = 0; b < keys_len && b < MAX_KEYS; b++)
                        keys[b*CODE_W +: CODE_W] = alphabet[$urandom_range(0, 3)];
                queue_search(keys, LEN_W'(keys_len),
                             ($urandom_range(0, 4) != 0) ? TOL_W'($urandom_range(0, 3))
                                                         : TOL_W'($urandom_range(0, 15)));
            end
            else if (roll < 95)
                queue_beat(random_beat(OP_CLEAR));
            else
                queue_beat(random_beat(OP_UNDEFINED));
        end
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (beats_to_send.size() != 0 || s_tvalid || replies_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        capacity_setting = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : run_limit
        #(30_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [CAP_W-1:0] capacities [12];
        int               waited;
        capacities = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd7, 4'd4, 4'd6,
                       4'd9, 4'd12, 4'd5};
        capacity_setting = CAPACITY_RESET;
        head_slot = 0;
        fill_count = 0;
        resume_pos = 0;
        for (int i = 0; i < DEPTH; i++)
            window_marks[i] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening under the reset capacity
        queue_search(64'h0, 4'd1, 4'd0);
        queue_push(8'h00);
        queue_push(8'hFF);
        queue_push(8'hA5);
        queue_push(8'h5A);
        queue_push(8'h3C);
        queue_push(8'hC3);
        queue_search(64'h0000_0000_00C3_5AFF, 4'd3, 4'd2);
        queue_search(64'h0000_0000_00C3_5AFF, 4'd3, 4'd2);
        queue_beat('{OP_UNDEFINED, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 4'hF});
        queue_push(8'hFF);
        queue_search(64'h0, 4'd0, 4'd8);
        queue_search(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15);
        queue_beat(random_beat(OP_CLEAR));
        queue_push(8'h11);
        queue_push(8'h22);
        queue_push(8'h11);
        queue_push(8'h22);
        queue_search(64'h2211, 4'd2, 4'd0);
        queue_search(64'h1111, 4'd2, 4'd8);
        queue_push(8'h5A);
        queue_search(64'h5A, 4'd9, 4'd0);
        queue_search(64'h5A_2211, 4'd3, 4'd1);
        queue_beat(random_beat(OP_CLEAR));
        queue_search(64'h11, 4'd1, 4'd0);

        for (int p = 0; p < 12; p++)
        begin
            wait_for_drain();
            write_capacity(capacities[p]);
            // every fourth phase runs with no idling on either side; phase 3 keeps its sender from idling
            sender_idles = (p % 4 != 1) && (p != 3);
            receiver_idles = (p % 4 != 1);
            if (p == 3)
                long_hold_request = 1'b1;
            queue_random_phase(RANDOM_PER_PHASE);
        end

        waited = 0;
        while ((beats_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (replies_due.size() != 0)
        begin
            error_count++;
            $error("%0d predicted replies never arrived", replies_due.size());
        end

        $display("run covered %0d beats over 12 capacity settings plus reset: %0d replies checked",
                 beats_accepted, replies_checked);
        $display("searches that hit: %0d, replies with newly marked entries: %0d",
                 hits_seen, marked_seen);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
